// File: rtl/tvfg_pkg.sv
// Shared types, register codes and the CORDIC arctangent table for the torus generator.
`timescale 1ns / 1ps
package tvfg_pkg;

  localparam int MAX_BANDS_DEF  = 256;
  localparam int MAX_SEGS_DEF   = 256;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 28;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  localparam logic [1:0] REG_OUTER_RADIUS = 2'd0;
  localparam logic [1:0] REG_INNER_RADIUS = 2'd1;
  localparam logic [1:0] REG_BAND_COUNT   = 2'd2;
  localparam logic [1:0] REG_SEG_COUNT    = 2'd3;

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] band;
    logic       err;
  } sideband_t;

  function automatic logic signed [31:0] atan_turn(input int step);
    logic signed [31:0] v;
    begin
      unique case (step)
        0: v = 32'sd536870912;
        1: v = 32'sd316933406;
        2: v = 32'sd167458907;
        3: v = 32'sd85004756;
        4: v = 32'sd42667331;
        5: v = 32'sd21354465;
        6: v = 32'sd10679838;
        7: v = 32'sd5340245;
        8: v = 32'sd2670163;
        9: v = 32'sd1335087;
        10: v = 32'sd667544;
        11: v = 32'sd333772;
        12: v = 32'sd166886;
        13: v = 32'sd83443;
        14: v = 32'sd41722;
        15: v = 32'sd20861;
        16: v = 32'sd10430;
        17: v = 32'sd5215;
        18: v = 32'sd2608;
        19: v = 32'sd1304;
        20: v = 32'sd652;
        21: v = 32'sd326;
        22: v = 32'sd163;
        23: v = 32'sd81;
        24: v = 32'sd41;
        25: v = 32'sd20;
        26: v = 32'sd10;
        27: v = 32'sd5;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: rtl/tvfg_div_cell.sv
// One restoring division step that yields one quotient bit of the angle phase.
`timescale 1ns / 1ps
module tvfg_div_cell #(
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [8:0]    count,
  input  logic [8:0]    rem_i,
  input  logic [QW-1:0] quo_i,
  output logic [8:0]    rem_o,
  output logic [QW-1:0] quo_o
);

  logic [8:0]    rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [9:0]    rem2;
  logic          ge;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    ge      = rem2 >= {1'b0, count};
    rem_nxt = ge ? 9'(rem2 - {1'b0, count}) : rem2[8:0];
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// File: rtl/tvfg_cordic_cell.sv
// One CORDIC rotation step with its quadrant tag carried alongside.
`timescale 1ns / 1ps
module tvfg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  input  logic signed [31:0] z_i,
  input  logic [1:0]         quad_i,
  output logic signed [32:0] x_o,
  output logic signed [32:0] y_o,
  output logic signed [31:0] z_o,
  output logic [1:0]         quad_o
);

  localparam logic signed [31:0] ATAN = tvfg_pkg::atan_turn(STEP);

  logic signed [32:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [1:0]         quad_r;

  always_comb begin
    if (!z_i[31]) begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign quad_o = quad_r;

endmodule

// File: rtl/torus_vertex_and_face_generator.sv
// Top level of the torus vertex and grid-cell generator pipeline.
`timescale 1ns / 1ps
// Takes one grid point per cycle while the output is not stalled, and returns its
// position and the four corner indices of the cell that starts there. It is a chain of
// cells: ANGLE_BITS + 1 division cells form each angle's phase and 28 CORDIC cells turn
// it into cosine and sine, both angles side by side, followed by two multiply stages.
// The whole chain advances whenever the output register is empty or being read, so a
// stalled result holds the pipeline and input ready together.
module torus_vertex_and_face_generator #(
  parameter int MAX_BANDS  = tvfg_pkg::MAX_BANDS_DEF,
  parameter int MAX_SEGS   = tvfg_pkg::MAX_SEGS_DEF,
  parameter int ANGLE_BITS = tvfg_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_seg_index,
  input  logic [7:0]          in_band_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  out_pos_x,
  output logic signed [17:0]  out_pos_y,
  output logic signed [16:0]  out_pos_z,
  output logic [15:0]         out_corner_a,
  output logic [15:0]         out_corner_b,
  output logic [15:0]         out_corner_c,
  output logic [15:0]         out_corner_d,
  output logic                out_index_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int QW    = ANGLE_BITS + 1;
  localparam int NDIV  = ANGLE_BITS + 1;
  localparam int NCOR  = tvfg_pkg::CORDIC_STEPS;
  localparam int SB_N  = NDIV + NCOR + 3;
  localparam int NST   = NDIV + NCOR + 5;

  logic [15:0] outer_radius_r, inner_radius_r;
  logic [8:0]  band_count_r, seg_count_r;

  logic [NST-1:0] vld_r;
  logic           en;

  tvfg_pkg::sideband_t sb_r [SB_N];
  tvfg_pkg::sideband_t sb_nxt;

  logic [8:0]    rem_w [2][NDIV+1];
  logic [QW-1:0] quo_w [2][NDIV+1];
  logic [8:0]    cnt_w [2];

  logic signed [32:0] cx_w [2][NCOR+1];
  logic signed [32:0] cy_w [2][NCOR+1];
  logic signed [31:0] cz_w [2][NCOR+1];
  logic [1:0]         cq_w [2][NCOR+1];

  logic signed [17:0] cos_r [2];
  logic signed [17:0] sin_r [2];

  logic signed [35:0] ring_r;
  logic signed [34:0] zp_r;
  logic signed [17:0] c2_r, s2_r;
  logic [15:0]        ca_r, cb_r, cc_r, cd_r;
  logic               err2_r;

  logic signed [17:0] px_r, py_r;
  logic signed [16:0] pz_r;
  logic [15:0]        oa_r, ob_r, oc_r, od_r;
  logic               oerr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_radius_r <= 16'd2560;
      inner_radius_r <= 16'd768;
      band_count_r   <= 9'd16;
      seg_count_r    <= 9'd24;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tvfg_pkg::REG_OUTER_RADIUS: outer_radius_r <= cfg_data;
        tvfg_pkg::REG_INNER_RADIUS: inner_radius_r <= cfg_data;
        tvfg_pkg::REG_BAND_COUNT:   band_count_r   <= cfg_data[8:0];
        tvfg_pkg::REG_SEG_COUNT:    seg_count_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_comb begin
    sb_nxt.seg  = in_seg_index;
    sb_nxt.band = in_band_index;
    sb_nxt.err  = ({1'b0, in_band_index} >= band_count_r)
               || ({1'b0, in_seg_index} >= seg_count_r)
               || ({2'b00, band_count_r} > 11'(MAX_BANDS))
               || ({2'b00, seg_count_r} > 11'(MAX_SEGS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_nxt;
      for (int k = 1; k < SB_N; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign cnt_w[0]    = band_count_r;
  assign cnt_w[1]    = seg_count_r;
  assign rem_w[0][0] = {1'b0, sb_r[0].band};
  assign rem_w[1][0] = {1'b0, sb_r[0].seg};
  assign quo_w[0][0] = '0;
  assign quo_w[1][0] = '0;

  for (genvar a = 0; a < 2; a++) begin : g_ang
    logic [QW:0]        psum;
    logic [31:0]        ph, sh;
    logic signed [32:0] x0_r;
    logic signed [32:0] y0_r;
    logic signed [31:0] z0_r;
    logic [1:0]         q0_r;
    logic signed [32:0] csel, ssel, cadd, sadd;

    for (genvar d = 0; d < NDIV; d++) begin : g_div
      tvfg_div_cell #(.QW(QW)) u_div (
        .clk   (clk),
        .en    (en),
        .count (cnt_w[a]),
        .rem_i (rem_w[a][d]),
        .quo_i (quo_w[a][d]),
        .rem_o (rem_w[a][d+1]),
        .quo_o (quo_w[a][d+1])
      );
    end

    always_comb begin
      psum = {1'b0, quo_w[a][NDIV]} + {{QW{1'b0}}, 1'b1};
      ph   = {psum[ANGLE_BITS:1], {(32 - ANGLE_BITS){1'b0}}};
      sh   = ph + 32'h2000_0000;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x0_r <= tvfg_pkg::CORDIC_X0;
        y0_r <= '0;
        z0_r <= $signed({2'b00, sh[29:0]}) - 32'sh2000_0000;
        q0_r <= sh[31:30];
      end
    end

    assign cx_w[a][0] = x0_r;
    assign cy_w[a][0] = y0_r;
    assign cz_w[a][0] = z0_r;
    assign cq_w[a][0] = q0_r;

    for (genvar s = 0; s < NCOR; s++) begin : g_cor
      tvfg_cordic_cell #(.STEP(s)) u_cor (
        .clk    (clk),
        .en     (en),
        .x_i    (cx_w[a][s]),
        .y_i    (cy_w[a][s]),
        .z_i    (cz_w[a][s]),
        .quad_i (cq_w[a][s]),
        .x_o    (cx_w[a][s+1]),
        .y_o    (cy_w[a][s+1]),
        .z_o    (cz_w[a][s+1]),
        .quad_o (cq_w[a][s+1])
      );
    end

    always_comb begin
      unique case (cq_w[a][NCOR])
        2'd0: begin csel = cx_w[a][NCOR];  ssel = cy_w[a][NCOR];  end
        2'd1: begin csel = -cy_w[a][NCOR]; ssel = cx_w[a][NCOR];  end
        2'd2: begin csel = -cx_w[a][NCOR]; ssel = -cy_w[a][NCOR]; end
        default: begin csel = cy_w[a][NCOR]; ssel = -cx_w[a][NCOR]; end
      endcase
      cadd = csel + 33'sd8192;
      sadd = ssel + 33'sd8192;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cos_r[a] <= cadd[31:14];
        sin_r[a] <= sadd[31:14];
      end
    end
  end

  logic signed [16:0] rin_s;
  logic signed [34:0] rc1, rs1;
  logic [8:0]         nb, ns, bnd9, seg9;
  logic [16:0]        pa, pb, pc, pd;
  tvfg_pkg::sideband_t sbl;

  always_comb begin
    sbl   = sb_r[SB_N-1];
    rin_s = $signed({1'b0, inner_radius_r});
    rc1   = rin_s * cos_r[0];
    rs1   = rin_s * sin_r[0];
    bnd9  = {1'b0, sbl.band};
    seg9  = {1'b0, sbl.seg};
    nb    = (bnd9 + 9'd1 == band_count_r) ? 9'd0 : bnd9 + 9'd1;
    ns    = (seg9 + 9'd1 == seg_count_r) ? 9'd0 : seg9 + 9'd1;
    pa    = 17'(seg9 * band_count_r);
    pc    = 17'(ns * band_count_r);
    pb    = pa;
    pd    = pc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ring_r <= $signed({4'b0000, outer_radius_r, 16'h0000}) + 36'(rc1);
      zp_r   <= rs1;
      c2_r   <= cos_r[1];
      s2_r   <= sin_r[1];
      ca_r   <= 16'(pa + {8'h00, bnd9});
      cb_r   <= 16'(pb + {8'h00, nb});
      cc_r   <= 16'(pc + {8'h00, bnd9});
      cd_r   <= 16'(pd + {8'h00, nb});
      err2_r <= sbl.err;
    end
  end

  logic signed [53:0] xp, yp;
  logic signed [21:0] xs, ys;
  logic signed [18:0] zs;
  logic signed [17:0] xsat, ysat;
  logic signed [16:0] zsat;

  always_comb begin
    xp = ring_r * c2_r;
    yp = ring_r * s2_r;
    xp = xp + 54'sh8000_0000;
    yp = yp + 54'sh8000_0000;
    xs = xp[53:32];
    ys = yp[53:32];
    zs = 19'((zp_r + 35'sh8000) >>> 16);
    if (xs > 22'sd131071) begin
      xsat = 18'sd131071;
    end else if (xs < -22'sd131072) begin
      xsat = -18'sd131072;
    end else begin
      xsat = xs[17:0];
    end
    if (ys > 22'sd131071) begin
      ysat = 18'sd131071;
    end else if (ys < -22'sd131072) begin
      ysat = -18'sd131072;
    end else begin
      ysat = ys[17:0];
    end
    if (zs > 19'sd65535) begin
      zsat = 17'sd65535;
    end else if (zs < -19'sd65536) begin
      zsat = -17'sd65536;
    end else begin
      zsat = zs[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= err2_r ? '0 : xsat;
      py_r   <= err2_r ? '0 : ysat;
      pz_r   <= err2_r ? '0 : zsat;
      oa_r   <= err2_r ? '0 : ca_r;
      ob_r   <= err2_r ? '0 : cb_r;
      oc_r   <= err2_r ? '0 : cc_r;
      od_r   <= err2_r ? '0 : cd_r;
      oerr_r <= err2_r;
    end
  end

  assign out_pos_x       = px_r;
  assign out_pos_y       = py_r;
  assign out_pos_z       = pz_r;
  assign out_corner_a    = oa_r;
  assign out_corner_b    = ob_r;
  assign out_corner_c    = oc_r;
  assign out_corner_d    = od_r;
  assign out_index_error = oerr_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_pos_x == 18'sd0 && out_pos_z == 17'sd0
      && out_corner_a == 16'd0 && out_corner_d == 16'd0)
    else $error("error beat carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
